// ----- rtl/core/mineral_radiative_conductivity_eval_defines.svh -----
// assertion macros used by the checker file
`ifndef MINERAL_RADIATIVE_CONDUCTIVITY_EVAL_DEFINES_SVH
`define MINERAL_RADIATIVE_CONDUCTIVITY_EVAL_DEFINES_SVH

// checked outside reset only
`define MRCE_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// checked through reset as well
`define MRCE_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

// ----- rtl/core/mrce_pkg.sv -----
// constants, coefficient table and constant helpers for the conductivity pipeline
`default_nettype none
package mrce_pkg;

   localparam int TEMP_W    = 16;
   localparam int FRAC_W    = 16;
   localparam int COND_W    = 32;
   localparam int SEL_W     = 2;
   localparam int ACC_W     = 48;
   localparam int N_MINERAL = 4;
   localparam int N_COEF    = 7;
   localparam int LOG_ITER  = 24;
   localparam int EXP_ITER  = 24;
   localparam int MANT_W    = 31;

   localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
   localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};
   localparam logic [COND_W-1:0] COND_ONE = 32'h0100_0000;
   localparam logic [COND_W-1:0] COND_SAT = 32'hFFFF_FFFF;

   // round(num * 2^(39 + 10k) / 10^dec), ties away from zero, by long division
   function automatic logic signed [ACC_W-1:0] make_coef(input longint num, input int dec,
                                                        input int k);
      logic [63:0] mag;
      logic [63:0] den;
      logic [63:0] q;
      logic [63:0] rem;
      int          sh;
      mag = (num < 0) ? 64'(-num) : 64'(num);
      den = 64'd1;
      for (int i = 0; i < dec; i++) den = den * 64'd5;
      sh  = 39 + 10 * k - dec;
      q   = '0;
      rem = '0;
      for (int b = 19; b >= 0; b--) begin
         rem = {rem[62:0], mag[b]};
         q   = {q[62:0], 1'b0};
         if (rem >= den) begin
            q[0] = 1'b1;
            rem  = rem - den;
         end
      end
      for (int i = 0; i < sh; i++) begin
         rem = {rem[62:0], 1'b0};
         q   = {q[62:0], 1'b0};
         if (rem >= den) begin
            q[0] = 1'b1;
            rem  = rem - den;
         end
      end
      if ({rem[62:0], 1'b0} >= den) q = q + 64'd1;
      return (num < 0) ? ACC_W'(-q) : ACC_W'(q);
   endfunction

   function automatic logic [63:0] isqrt64(input logic [63:0] v_in);
      logic [63:0] v;
      logic [63:0] res;
      logic [63:0] bitv;
      v    = v_in;
      res  = '0;
      bitv = 64'd1 << 62;
      for (int i = 0; i < 32; i++) if (bitv > v) bitv = bitv >> 2;
      for (int i = 0; i < 32; i++) begin
         if (bitv != 0) begin
            if (v >= res + bitv) begin
               v   = v - (res + bitv);
               res = (res >> 1) + bitv;
            end else begin
               res = res >> 1;
            end
            bitv = bitv >> 2;
         end
      end
      return res;
   endfunction

   // 2^(2^-k) in Q2.30 by repeated square roots
   function automatic logic [31:0] exp_root(input int k);
      logic [63:0] t;
      t = 64'd1 << 31;
      for (int j = 1; j <= k; j++) t = isqrt64(t << 30);
      return t[31:0];
   endfunction

   localparam logic signed [ACC_W-1:0] COEF_TBL [0:N_MINERAL-1][0:N_COEF-1] = '{
      '{make_coef(35642, 4, 0), make_coef(-63992, 7, 1), make_coef(-58916, 9, 2),
        make_coef(20180, 11, 3), make_coef(-21556, 14, 4), make_coef(96310, 18, 5),
        make_coef(-155654, 22, 6)},
      '{make_coef(52465, 5, 0), make_coef(-29525, 7, 1), make_coef(39123, 10, 2),
        make_coef(77844, 14, 3), make_coef(128493, 18, 4), make_coef(0, 0, 5),
        make_coef(0, 0, 6)},
      '{make_coef(-11439, 5, 0), make_coef(143647, 8, 1), make_coef(-60070, 10, 2),
        make_coef(90912, 13, 3), make_coef(-197192, 17, 4), make_coef(0, 0, 5),
        make_coef(0, 0, 6)},
      '{make_coef(147437, 5, 0), make_coef(-95198, 7, 1), make_coef(206795, 10, 2),
        make_coef(-176979, 13, 3), make_coef(59028, 16, 4), make_coef(0, 0, 5),
        make_coef(0, 0, 6)}
   };

endpackage
`default_nettype wire

// ----- rtl/core/mineral_radiative_conductivity_eval.sv -----
// conductivity pipeline: horner polynomial, log2, scale by fraction, exp2, output skid
// throughput: one item per cycle while the skid is empty, over 64 register stages,
//   each holding one multiply (horner step, log2 squaring or exp2 root) or a small
//   shift/encode step
// output stall: the pipeline moves until one more result sits in the skid, then holds
// reset (synchronous) clears all valid bits, the skid and mineral_select (dry olivine)
`default_nettype none
module mineral_radiative_conductivity_eval (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          csr_write,
   input  wire logic [mrce_pkg::SEL_W-1:0]    csr_mineral_select,
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire logic [mrce_pkg::TEMP_W-1:0]   req_temperature,
   input  wire logic [mrce_pkg::FRAC_W-1:0]   req_mineral_fraction,
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output logic [mrce_pkg::COND_W-1:0]        rsp_conductivity,
   output logic                               rsp_base_not_positive
);

   localparam int NSTG   = 64;
   localparam int S_ENC  = 13;
   localparam int S_NORM = 14;
   localparam int S_Y    = S_NORM + mrce_pkg::LOG_ITER + 1;
   localparam int S_LAST = S_Y + mrce_pkg::EXP_ITER;
   localparam int ACC_W  = mrce_pkg::ACC_W;
   localparam int MW     = mrce_pkg::MANT_W;

   logic [mrce_pkg::SEL_W-1:0] sel_ff;
   logic                       en;
   logic [NSTG-1:0]            vld_ff;

   logic [mrce_pkg::TEMP_W-1:0] temp_ff [0:10];
   logic [mrce_pkg::FRAC_W-1:0] frac_ff [0:NSTG-1];
   logic signed [63:0]          hp_ff [1:6];
   logic signed [ACC_W-1:0]     ha_ff [1:6];
   logic [5:0]                  e_ff [S_ENC:S_Y-1];
   logic [ACC_W-2:0]            v_ff;
   logic                        npos_ff [S_ENC:NSTG-1];
   logic [MW-1:0]               m_ff [S_NORM:S_Y-1];
   logic [mrce_pkg::LOG_ITER-1:0] fr_ff [S_NORM+1:S_Y-1];
   logic signed [32:0]          y_ff [S_Y:NSTG-1];
   logic [MW-1:0]               p_ff [S_Y+1:NSTG-1];

   // configuration register
   always_ff @(posedge clock) begin
      if (reset) begin
         sel_ff <= '0;
      end else if (csr_write) begin
         sel_ff <= csr_mineral_select;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[NSTG-2:0], req_valid};
      end
   end

   assign req_ready = en;

   always_ff @(posedge clock) begin
      if (en) begin
         temp_ff[0] <= req_temperature;
         frac_ff[0] <= req_mineral_fraction;
      end
   end

   for (genvar s = 1; s <= 10; s++) begin : g_temp
      always_ff @(posedge clock) begin
         if (en) temp_ff[s] <= temp_ff[s-1];
      end
   end

   for (genvar s = 1; s < NSTG; s++) begin : g_frac
      always_ff @(posedge clock) begin
         if (en) frac_ff[s] <= frac_ff[s-1];
      end
   end

   // horner: multiply stage then shift, add and saturate stage
   for (genvar j = 1; j <= 6; j++) begin : g_horner
      logic signed [ACC_W-1:0] acc_prev;
      logic signed [64:0]      prod;
      logic signed [64:0]      sum;
      logic signed [ACC_W-1:0] hp_in;
      logic signed [ACC_W-1:0] ha_in;
      if (j == 1) begin : g_first
         assign acc_prev = mrce_pkg::COEF_TBL[sel_ff][6];
      end else begin : g_rest
         assign acc_prev = ha_ff[j-1];
      end
      assign prod = acc_prev * $signed({1'b0, temp_ff[2*j-2]});
      assign sum  = (hp_ff[j] >>> 14) + mrce_pkg::COEF_TBL[sel_ff][6-j];
      always_comb begin
         if (sum > 65'(mrce_pkg::ACC_MAX)) begin
            ha_in = mrce_pkg::ACC_MAX;
         end else if (sum < 65'(mrce_pkg::ACC_MIN)) begin
            ha_in = mrce_pkg::ACC_MIN;
         end else begin
            ha_in = sum[ACC_W-1:0];
         end
      end
      assign hp_in = '0;
      always_ff @(posedge clock) begin
         if (en) begin
            hp_ff[j] <= prod[63:0] | 64'(hp_in);
            ha_ff[j] <= ha_in;
         end
      end
   end

   // msb search on the polynomial value
   logic [5:0] e_in;
   always_comb begin
      e_in = '0;
      for (int i = 0; i < ACC_W - 1; i++) begin
         if (ha_ff[6][i]) e_in = 6'(i);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         e_ff[S_ENC]    <= e_in;
         v_ff           <= ha_ff[6][ACC_W-2:0];
         npos_ff[S_ENC] <= ha_ff[6][ACC_W-1] || (ha_ff[6] == '0);
      end
   end

   for (genvar s = S_ENC + 1; s < S_Y; s++) begin : g_ecarry
      always_ff @(posedge clock) begin
         if (en) e_ff[s] <= e_ff[s-1];
      end
   end

   for (genvar s = S_ENC + 1; s < NSTG; s++) begin : g_npos
      always_ff @(posedge clock) begin
         if (en) npos_ff[s] <= npos_ff[s-1];
      end
   end

   // normalize mantissa to Q1.30
   logic [ACC_W-2+30:0] norm_wide;
   assign norm_wide = {v_ff, 30'b0} >> e_ff[S_ENC];

   always_ff @(posedge clock) begin
      if (en) m_ff[S_NORM] <= norm_wide[MW-1:0];
   end

   // log2 fraction bits, one squaring per stage
   for (genvar i = 1; i <= mrce_pkg::LOG_ITER; i++) begin : g_log
      logic [2*MW-1:0] sq;
      logic [MW:0]     sqs;
      logic [MW-1:0]   m_in;
      logic [mrce_pkg::LOG_ITER-1:0] fr_prev;
      assign sq   = m_ff[S_NORM+i-1] * m_ff[S_NORM+i-1];
      assign sqs  = sq[2*MW-1:30];
      assign m_in = sqs[MW] ? sqs[MW:1] : sqs[MW-1:0];
      if (i == 1) begin : g_first
         assign fr_prev = '0;
      end else begin : g_rest
         assign fr_prev = fr_ff[S_NORM+i-1];
      end
      always_ff @(posedge clock) begin
         if (en) begin
            m_ff[S_NORM+i]  <= m_in;
            fr_ff[S_NORM+i] <= {fr_prev[mrce_pkg::LOG_ITER-2:0], sqs[MW]};
         end
      end
   end

   // log2 times fraction
   logic signed [6:0]  e_sub;
   logic signed [30:0] log_q24;
   logic signed [47:0] y_prod;
   assign e_sub   = $signed({1'b0, e_ff[S_Y-1]}) - 7'sd40;
   assign log_q24 = $signed({e_sub, fr_ff[S_Y-1]});
   assign y_prod  = log_q24 * $signed({1'b0, frac_ff[S_Y-1]});

   always_ff @(posedge clock) begin
      if (en) y_ff[S_Y] <= y_prod[47:15];
   end

   for (genvar s = S_Y + 1; s < NSTG; s++) begin : g_ycarry
      always_ff @(posedge clock) begin
         if (en) y_ff[s] <= y_ff[s-1];
      end
   end

   // exp2 of the fraction part, one root factor per stage
   for (genvar k = 1; k <= mrce_pkg::EXP_ITER; k++) begin : g_exp
      localparam logic [31:0] ROOT = mrce_pkg::exp_root(k);
      logic [MW-1:0]    p_prev;
      logic [MW+31:0]   pm;
      if (k == 1) begin : g_first
         assign p_prev = MW'(1) << 30;
      end else begin : g_rest
         assign p_prev = p_ff[S_Y+k-1];
      end
      assign pm = p_prev * ROOT;
      always_ff @(posedge clock) begin
         if (en) begin
            p_ff[S_Y+k] <= y_ff[S_Y+k-1][mrce_pkg::EXP_ITER-k] ? pm[MW+29:30] : p_prev;
         end
      end
   end

   // integer part scaling and special cases
   logic signed [8:0]           n_int;
   logic [9:0]                  shr;
   logic [mrce_pkg::COND_W-1:0] fin_cond;
   assign n_int = y_ff[S_LAST][32:24];
   assign shr   = 10'(10'sd6 - 10'(n_int));

   always_comb begin
      if (npos_ff[S_LAST]) begin
         fin_cond = (frac_ff[S_LAST] == '0) ? mrce_pkg::COND_ONE : '0;
      end else if (n_int >= 9'sd8) begin
         fin_cond = mrce_pkg::COND_SAT;
      end else if (n_int == 9'sd7) begin
         fin_cond = {p_ff[S_LAST], 1'b0};
      end else begin
         fin_cond = 32'(p_ff[S_LAST]) >> shr;
      end
   end

   // output register and skid
   logic                        out_v_ff;
   logic [mrce_pkg::COND_W-1:0] out_c_ff;
   logic                        out_n_ff;
   logic                        skid_v_ff;
   logic [mrce_pkg::COND_W-1:0] skid_c_ff;
   logic                        skid_n_ff;
   logic                        pop;
   logic                        exit_v;

   assign en     = !skid_v_ff;
   assign pop    = out_v_ff && rsp_ready;
   assign exit_v = en && vld_ff[S_LAST];

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff  <= 1'b0;
         skid_v_ff <= 1'b0;
      end else if (skid_v_ff) begin
         if (pop) skid_v_ff <= 1'b0;
      end else if (exit_v) begin
         if (!out_v_ff || pop) begin
            out_v_ff <= 1'b1;
         end else begin
            skid_v_ff <= 1'b1;
         end
      end else if (pop) begin
         out_v_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (skid_v_ff) begin
         if (pop) begin
            out_c_ff <= skid_c_ff;
            out_n_ff <= skid_n_ff;
         end
      end else if (exit_v) begin
         if (!out_v_ff || pop) begin
            out_c_ff <= fin_cond;
            out_n_ff <= npos_ff[S_LAST];
         end else begin
            skid_c_ff <= fin_cond;
            skid_n_ff <= npos_ff[S_LAST];
         end
      end
   end

   assign rsp_valid             = out_v_ff;
   assign rsp_conductivity      = out_c_ff;
   assign rsp_base_not_positive = out_n_ff;

endmodule
`default_nettype wire

// ----- rtl/core/mrce_checker.sv -----
// port-level checks for the conductivity pipeline, bound to the top level
`default_nettype none
`include "mineral_radiative_conductivity_eval_defines.svh"
module mrce_props (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_ready,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic [31:0] rsp_conductivity,
   input wire logic        rsp_base_not_positive
);

   logic [32:0] rsp_word;
   logic        npos_value_ok;

   assign rsp_word      = {rsp_conductivity, rsp_base_not_positive};
   assign npos_value_ok = (rsp_conductivity == '0) || (rsp_conductivity == mrce_pkg::COND_ONE);

   `MRCE_ASSERT_ALWAYS(a_reset_empty, reset |=> (!rsp_valid && req_ready), "busy after reset")
   `MRCE_ASSERT(a_rsp_hold, rsp_valid && !rsp_ready |=> rsp_valid, "result dropped while stalled")
   `MRCE_ASSERT(a_rsp_stable, rsp_valid && !rsp_ready |=> $stable(rsp_word), "held result changed")
   `MRCE_ASSERT(a_npos_value, rsp_valid && rsp_base_not_positive |-> npos_value_ok, "bad npos result")

endmodule

bind mineral_radiative_conductivity_eval mrce_props u_mrce_props (
   .clock                 (clock),
   .reset                 (reset),
   .req_ready             (req_ready),
   .rsp_valid             (rsp_valid),
   .rsp_ready             (rsp_ready),
   .rsp_conductivity      (rsp_conductivity),
   .rsp_base_not_positive (rsp_base_not_positive)
);
`default_nettype wire
